[rtl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types for the max-heap priority queue
// Token, write-back, fetch and response records passed along the level chain.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // index width covers heap slots up to 2^17-1 (largest supported capacity)
  localparam int IDX_W = 17;
  localparam int LVL_W = 5;
  localparam int KEY_W = 32;

  typedef enum logic {
    OP_INS,
    OP_DEL
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // operation handed from one level to the next
  typedef struct packed {
    logic                    valid;
    op_t                     op;
    logic [IDX_W-1:0]        q;      // parent offset within the level above
    logic [IDX_W-1:0]        path;   // insert path, next branch in the top bit
    logic [LVL_W-1:0]        depth;  // insert target level
    logic [IDX_W-1:0]        m;      // entries held after this item
    logic signed [KEY_W-1:0] key;
  } tok_t;

  // write-back of a key into the parent slot, level below to level above
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } upw_t;

  // broadcast read of the last slot before a remove
  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] depth;
    logic [IDX_W-1:0] q;             // slot offset within that level
  } fetch_t;

  typedef struct packed {
    logic                    done;
    logic signed [KEY_W-1:0] fkey;   // zero unless this level served the fetch
  } rsp_t;

  function automatic logic [LVL_W-1:0] msb_pos(input logic [IDX_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (v[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/mhpq_level_cell.sv]
// ----------------------------------------------------------------------------
// mhpq_level_cell: one level of the heap
// Holds the level's slots as left/right sibling memories, runs one step of an
// insert or remove per token, and writes back into the level above.
// ----------------------------------------------------------------------------
module mhpq_level_cell #(
  parameter int LEVEL = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  mhpq_pkg::tok_t   tok_in,
  output mhpq_pkg::tok_t   tok_out,
  input  mhpq_pkg::upw_t   upw_in,
  output mhpq_pkg::upw_t   upw_out,
  input  mhpq_pkg::fetch_t fetch,
  output mhpq_pkg::rsp_t   rsp
);

  localparam int RW    = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int DEPTH = 1 << RW;
  localparam int IW    = mhpq_pkg::IDX_W;
  localparam int KW    = mhpq_pkg::KEY_W;

  logic signed [KW-1:0] meml [DEPTH];
  logic signed [KW-1:0] memr [DEPTH];

  logic signed [KW-1:0] rdl, rdr;
  mhpq_pkg::tok_t       tok_r;
  logic                 act;
  logic                 fsel, fside;
  logic [RW-1:0]        pos_row;
  logic                 pos_side;
  logic                 done;

  // read port
  logic          fhit, ren;
  logic [RW-1:0] raddr;

  assign fhit  = fetch.valid && (fetch.depth == mhpq_pkg::LVL_W'(LEVEL));
  assign ren   = fhit || tok_in.valid;
  assign raddr = fhit ? fetch.q[RW:1] : tok_in.q[RW-1:0];

  // step decision
  logic [RW-1:0]        row;
  logic                 side_i, has_r, pick, deeper, gt_ins;
  logic signed [KW-1:0] e, ck;
  logic [IW-1:0]        c0, cidx;
  mhpq_pkg::tok_t       tok_next;
  mhpq_pkg::upw_t       upw_next;
  logic                 done_next, save_pos;
  logic                 lw_en, lw_side;
  logic signed [KW-1:0] lw_key;

  always_comb begin
    row    = tok_r.q[RW-1:0];
    side_i = tok_r.path[IW-1];
    e      = side_i ? rdr : rdl;
    gt_ins = tok_r.key > e;
    c0     = (IW'(1) << LEVEL) + {tok_r.q[IW-2:0], 1'b0};
    has_r  = c0 < tok_r.m;
    pick   = has_r && (rdl < rdr);
    ck     = pick ? rdr : rdl;
    cidx   = c0 + IW'(pick);
    deeper = {cidx, 1'b0} <= {1'b0, tok_r.m};

    tok_next       = tok_r;
    tok_next.valid = 1'b0;
    tok_next.path  = tok_r.path << 1;
    upw_next       = '0;
    done_next      = 1'b0;
    save_pos       = 1'b0;
    lw_en          = 1'b0;
    lw_side        = side_i;
    lw_key         = tok_r.key;

    if (act) begin
      case (tok_r.op)
        mhpq_pkg::OP_INS: begin
          tok_next.q = {tok_r.q[IW-2:0], side_i};
          if (tok_r.depth == mhpq_pkg::LVL_W'(LEVEL)) begin
            lw_en     = 1'b1;
            done_next = 1'b1;
          end else begin
            // swap the carried key in when it beats the slot on the path
            lw_en          = gt_ins;
            tok_next.valid = 1'b1;
            tok_next.key   = gt_ins ? e : tok_r.key;
          end
        end
        mhpq_pkg::OP_DEL: begin
          tok_next.q = {tok_r.q[IW-2:0], pick};
          lw_side    = pick;
          upw_next.valid = 1'b1;
          if (tok_r.key >= ck) begin
            upw_next.key = tok_r.key;
            done_next    = 1'b1;
          end else begin
            upw_next.key = ck;
            if (deeper) begin
              tok_next.valid = 1'b1;
              save_pos       = 1'b1;
            end else begin
              // promoted slot is a leaf: drop the moved key into it
              lw_en     = 1'b1;
              done_next = 1'b1;
            end
          end
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end
  end

  // write port: parent write-back from below, else this level's own step
  logic                 wen, wside;
  logic [RW-1:0]        wrow;
  logic signed [KW-1:0] wkey;

  always_comb begin
    if (upw_in.valid) begin
      wen   = 1'b1;
      wrow  = pos_row;
      wside = pos_side;
      wkey  = upw_in.key;
    end else begin
      wen   = lw_en;
      wrow  = row;
      wside = lw_side;
      wkey  = lw_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdl <= meml[raddr];
      rdr <= memr[raddr];
    end
    if (wen) begin
      if (wside) begin
        memr[wrow] <= wkey;
      end else begin
        meml[wrow] <= wkey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act           <= 1'b0;
      fsel          <= 1'b0;
      done          <= 1'b0;
      tok_out.valid <= 1'b0;
      upw_out.valid <= 1'b0;
    end else begin
      act     <= tok_in.valid;
      fsel    <= fhit;
      done    <= done_next;
      tok_out <= tok_next;
      upw_out <= upw_next;
    end
    if (tok_in.valid) begin
      tok_r <= tok_in;
    end
    if (fhit) begin
      fside <= fetch.q[0];
    end
    if (save_pos) begin
      pos_row  <= row;
      pos_side <= pick;
    end
  end

  assign rsp.done = done;
  assign rsp.fkey = fsel ? (fside ? rdr : rdl) : '0;

endmodule

[rtl/max_heap_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core: binary max-heap priority queue
// The root key is held in a register (level 0) and each deeper level is one
// level cell. One item at a time: the next item is taken in the cycle its
// result is presented, and a result waits in S_OUT while the output register
// is still full. Reset clears the count and the control state, not the keys.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] removed_key, [40:32] count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int NCELL = CW - 1;
  localparam int IW    = mhpq_pkg::IDX_W;
  localparam int LW    = mhpq_pkg::LVL_W;
  localparam int KW    = mhpq_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_FWAIT,
    S_RUN,
    S_OUT
  } state_t;

  state_t               state;
  logic [CW-1:0]        cnt;
  logic signed [KW-1:0] root;
  logic signed [KW-1:0] res_key;
  mhpq_pkg::st_t        res_status;
  mhpq_pkg::tok_t       tok_r;
  mhpq_pkg::fetch_t     fetch_r;

  mhpq_pkg::tok_t tok [NCELL+1];
  mhpq_pkg::upw_t upw [NCELL+1];
  mhpq_pkg::rsp_t rsp [1:NCELL];

  assign tok[0]     = tok_r;
  assign upw[NCELL] = '0;

  genvar g;
  for (g = 1; g <= NCELL; g++) begin : g_cell
    mhpq_level_cell #(.LEVEL(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g-1]),
      .tok_out (tok[g]),
      .upw_in  (upw[g]),
      .upw_out (upw[g-1]),
      .fetch   (fetch_r),
      .rsp     (rsp[g])
    );
  end

  logic [NCELL-1:0]     done_vec;
  logic                 any_done;
  logic signed [KW-1:0] fkey_or;

  always_comb begin
    fkey_or = '0;
    for (int i = 1; i <= NCELL; i++) begin
      done_vec[i-1] = rsp[i].done;
      fkey_or       = fkey_or | rsp[i].fkey;
    end
    any_done = |done_vec;
  end

  // path and level of the new last slot (insert) and of the current last slot
  logic signed [KW-1:0] in_key;
  logic [IW-1:0]        n_ins, n_del, path_ins, off_del;
  logic [LW-1:0]        d_ins, d_del;

  always_comb begin
    in_key   = $signed(s_axis_tdata);
    n_ins    = IW'(cnt) + IW'(1);
    n_del    = IW'(cnt);
    d_ins    = mhpq_pkg::msb_pos(n_ins);
    d_del    = mhpq_pkg::msb_pos(n_del);
    path_ins = n_ins << (LW'(IW) - d_ins);
    off_del  = n_del - (IW'(1) << d_del);
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      tok_r.valid   <= 1'b0;
      fetch_r.valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0] == 1'b0) begin
              res_key <= '0;
              if (cnt >= CW'(CAPACITY)) begin
                res_status <= mhpq_pkg::ST_FULL;
                state      <= S_OUT;
              end else if (cnt == '0) begin
                res_status <= mhpq_pkg::ST_OK;
                root       <= in_key;
                cnt        <= CW'(1);
                state      <= S_OUT;
              end else begin
                res_status  <= mhpq_pkg::ST_OK;
                cnt         <= cnt + CW'(1);
                tok_r.valid <= 1'b1;
                tok_r.op    <= mhpq_pkg::OP_INS;
                tok_r.q     <= '0;
                tok_r.path  <= path_ins;
                tok_r.depth <= d_ins;
                tok_r.m     <= n_ins;
                if (in_key > root) begin
                  root      <= in_key;
                  tok_r.key <= root;
                end else begin
                  tok_r.key <= in_key;
                end
                state <= S_RUN;
              end
            end else begin
              if (cnt == '0) begin
                res_status <= mhpq_pkg::ST_EMPTY;
                res_key    <= '0;
                state      <= S_OUT;
              end else begin
                res_status <= mhpq_pkg::ST_OK;
                res_key    <= root;
                cnt        <= cnt - CW'(1);
                if (cnt != CW'(1)) begin
                  fetch_r.valid <= 1'b1;
                  fetch_r.depth <= d_del;
                  fetch_r.q     <= off_del;
                  state         <= S_FETCH;
                end else begin
                  state <= S_OUT;
                end
              end
            end
          end
        end
        S_FETCH: begin
          fetch_r.valid <= 1'b0;
          state         <= S_FWAIT;
        end
        S_FWAIT: begin
          // the moved key lands in the root when only one key remains
          if (cnt == CW'(1)) begin
            root  <= fkey_or;
            state <= S_OUT;
          end else begin
            tok_r.valid <= 1'b1;
            tok_r.op    <= mhpq_pkg::OP_DEL;
            tok_r.q     <= '0;
            tok_r.path  <= '0;
            tok_r.depth <= '0;
            tok_r.m     <= IW'(cnt);
            tok_r.key   <= fkey_or;
            state       <= S_RUN;
          end
        end
        S_RUN: begin
          tok_r.valid <= 1'b0;
          if (upw[0].valid) begin
            root <= upw[0].key;
          end
          if (any_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {7'd0, 9'(cnt), res_key};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    !tok[NCELL].valid)
    else $error("token ran past the deepest level");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one level finished at once");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    any_done |-> state == S_RUN)
    else $error("level finished outside a heap walk");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != mhpq_pkg::ST_OK |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero removed key on a failed item");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for max_heap_priority_queue_core
// Drives insert and remove items on the input stream and checks each result
// (status, removed key, count) against a behavioral heap kept in the bench.
// A short directed table comes first, then random fill, drain and mixed runs
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int          CAP        = 256;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    mhpq_pkg::st_t                     status;
    logic signed [mhpq_pkg::KEY_W-1:0] removed_key;
    logic [8:0]                        count;
  } heap_result_t;

  typedef struct {
    mhpq_pkg::op_t                     op;
    logic signed [mhpq_pkg::KEY_W-1:0] key;
    bit                                typed;
    heap_result_t                      res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] key
  logic [0:0]  s_axis_tuser = '0;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] removed_key, [40:32] count
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // behavioral heap, slots 1..CAP
  logic signed [mhpq_pkg::KEY_W-1:0] model_heap [1:CAP];
  int                                model_count;

  heap_result_t pending_results [$];
  stim_row_t    dir_rows [$];
  int           error_count = 0;
  int unsigned  cycle_count = 0;
  int           send_idle_pct;
  int           recv_stall_pct;

  max_heap_priority_queue_core #(
    .CAPACITY(CAP)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // apply one item to the behavioral heap and return what the block must give
  task automatic heap_predict(input mhpq_pkg::op_t op,
                              input logic signed [mhpq_pkg::KEY_W-1:0] k,
                              output heap_result_t r);
    int                                i;
    int                                parent;
    int                                child;
    logic signed [mhpq_pkg::KEY_W-1:0] last;
    r.status      = mhpq_pkg::ST_OK;
    r.removed_key = '0;
    if (op == mhpq_pkg::OP_INS) begin
      if (model_count >= CAP) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        model_count++;
        i = model_count;
        while (i != 1 && k > model_heap[i/2]) begin
          model_heap[i] = model_heap[i/2];
          i = i / 2;
        end
        model_heap[i] = k;
      end
    end else begin
      if (model_count == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
      end else begin
        r.removed_key = model_heap[1];
        last   = model_heap[model_count];
        parent = 1;
        child  = 2;
        model_count--;
        while (child <= model_count) begin
          // right child wins only when strictly larger
          if (child < model_count && model_heap[child] < model_heap[child+1]) begin
            child++;
          end
          if (last >= model_heap[child]) break;
          model_heap[parent] = model_heap[child];
          parent = child;
          child  = child * 2;
        end
        model_heap[parent] = last;
      end
    end
    r.count = 9'(model_count);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input mhpq_pkg::op_t op,
                           input logic signed [mhpq_pkg::KEY_W-1:0] k,
                           input bit typed, input heap_result_t typed_res);
    heap_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    heap_predict(op, k, r);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // hold the input idle until every item in flight has produced its result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(input mhpq_pkg::op_t op,
                         input logic signed [mhpq_pkg::KEY_W-1:0] k,
                         input bit typed, input mhpq_pkg::st_t st,
                         input logic signed [mhpq_pkg::KEY_W-1:0] rk, input int cnt);
    stim_row_t row;
    row.op              = op;
    row.key             = k;
    row.typed           = typed;
    row.res.status      = st;
    row.res.removed_key = rk;
    row.res.count       = 9'(cnt);
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return mhpq_pkg::KEY_W'($signed($urandom_range(6)) - 3);   // ties
      default: return $urandom();
    endcase
  endfunction

  // mixed runs: pick a bias toward insert or remove for a stretch of items
  task automatic run_mixed(input int n_items);
    heap_result_t dummy;
    int           left;
    int           ins_pct;
    dummy = '{mhpq_pkg::ST_OK, '0, '0};
    left  = n_items;
    while (left > 0) begin
      case ($urandom_range(2))
        0:       ins_pct = 80;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      repeat ($urandom_range(80, 20)) begin
        if (left > 0) begin
          if ($urandom_range(63) == 0) wait_drained();
          send_item(($urandom_range(99) < ins_pct) ? mhpq_pkg::OP_INS : mhpq_pkg::OP_DEL,
                    pick_key(), 1'b0, dummy);
          left--;
        end
      end
    end
  endtask

  // fill to capacity, push past it, then drain and remove past empty
  task automatic run_fill_drain();
    heap_result_t dummy;
    dummy = '{mhpq_pkg::ST_OK, '0, '0};
    while (model_count < CAP) send_item(mhpq_pkg::OP_INS, pick_key(), 1'b0, dummy);
    repeat (3) send_item(mhpq_pkg::OP_INS, pick_key(), 1'b0, dummy);
    while (model_count > 0) send_item(mhpq_pkg::OP_DEL, pick_key(), 1'b0, dummy);
    repeat (2) send_item(mhpq_pkg::OP_DEL, pick_key(), 1'b0, dummy);
  endtask

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 48'(m_axis_tuser), 48'(want.status));
        if (m_axis_tdata[31:0] !== want.removed_key)
          report_mismatch("removed_key", 48'(m_axis_tdata[31:0]),
                          48'(unsigned'(want.removed_key)));
        if (m_axis_tdata[40:32] !== want.count)
          report_mismatch("count", 48'(m_axis_tdata[40:32]), 48'(want.count));
      end
    end
  end

  initial begin
    model_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // directed rows: empty remove, extreme keys, ties, full drain
    add_row(mhpq_pkg::OP_DEL, 32'sh0000_0000, 1'b1, mhpq_pkg::ST_EMPTY, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh7FFF_FFFF, 1'b1, mhpq_pkg::ST_OK, 0, 1);
    add_row(mhpq_pkg::OP_DEL, 32'sh0000_0000, 1'b1, mhpq_pkg::ST_OK, 32'sh7FFF_FFFF, 0);
    add_row(mhpq_pkg::OP_DEL, 32'shFFFF_FFFF, 1'b1, mhpq_pkg::ST_EMPTY, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh8000_0000, 1'b1, mhpq_pkg::ST_OK, 0, 1);
    add_row(mhpq_pkg::OP_INS, 32'sh7FFF_FFFF, 1'b1, mhpq_pkg::ST_OK, 0, 2);
    add_row(mhpq_pkg::OP_INS, 32'sh0000_0000, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'shFFFF_FFFF, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh0000_0005, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh0000_0005, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh0000_0005, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh0000_0001, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'sh5555_5555, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_INS, 32'shAAAA_AAAA, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    repeat (10) add_row(mhpq_pkg::OP_DEL, 32'sh1234_5678, 1'b0, mhpq_pkg::ST_OK, 0, 0);
    add_row(mhpq_pkg::OP_DEL, 32'sh0000_0000, 1'b1, mhpq_pkg::ST_EMPTY, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[n]) begin
      send_item(dir_rows[n].op, dir_rows[n].key, dir_rows[n].typed, dir_rows[n].res);
    end
    wait_drained();

    // no idling: full fill and drain, then mixed traffic
    run_fill_drain();
    run_mixed(250);
    wait_drained();

    send_idle_pct  = 77;
    recv_stall_pct = 0;
    run_mixed(200);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 77;
    run_mixed(200);
    wait_drained();

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_mixed(160);
    wait_drained();

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
